// ===== design/uff_pkg.sv =====
package uff_pkg;

   localparam int TX_DEPTH_DEFAULT = 8;
   localparam int RX_DEPTH_DEFAULT = 8;

   localparam logic [7:0] CH_XON  = 8'h11;
   localparam logic [7:0] CH_XOFF = 8'h13;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_RECV  = 2'd2;
   localparam logic [1:0] REQ_DONE  = 2'd3;

   typedef struct packed {
      logic       push0;
      logic       push1;
      logic       pop;
      logic [7:0] wdata0;
      logic [7:0] wdata1;
   } fifo_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic room_lt2;
      logic next_full;
      logic next_empty;
   } fifo_stat_type;

   typedef struct packed {
      logic       line_tx_valid;
      logic [7:0] line_tx_byte;
      logic       host_rd_valid;
      logic [7:0] host_rd_byte;
      logic       write_accepted;
      logic       tx_full;
      logic       rx_empty;
      logic       tx_stopped;
   } rsp_fields_type;

endpackage

// ===== design/uff_ram.sv =====
module uff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/uff_fifo.sv =====
module uff_fifo
   import uff_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  fifo_ctrl_type ctrl,
   output fifo_stat_type stat,
   output logic [7:0]    head
);

   // The ring is split into two banks so that two consecutive positions can be
   // written in the same cycle. Bit 0 of a position selects the bank.
   localparam int BD  = (DEPTH + 1) / 2;
   localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
   localparam int CW  = $clog2(DEPTH + 1);

   logic [BAW:0]  wp_ff, wp_in, rp_ff, rp_in, wp1;
   logic [CW-1:0] count_ff, count_in;
   logic          sel_ff, byp_valid_ff, byp_valid_in;
   logic [7:0]    byp_data_ff, byp_data_in;
   logic          we0, we1, hit0, hit1;
   logic [BAW-1:0] waddr0, waddr1;
   logic [7:0]    wd0, wd1, q0, q1;

   function automatic logic [BAW:0] pos_inc(input logic [BAW:0] p);
      logic [BAW-1:0] a;
      a = p[BAW:1];
      if (!p[0]) begin
         pos_inc = {a, 1'b1};
      end else begin
         pos_inc = {(a == BAW'(BD - 1)) ? '0 : a + 1'b1, 1'b0};
      end
   endfunction

   always_comb begin
      wp1 = pos_inc(wp_ff);
      if (ctrl.push1) begin
         wp_in = pos_inc(wp1);
      end else if (ctrl.push0) begin
         wp_in = wp1;
      end else begin
         wp_in = wp_ff;
      end
      rp_in = ctrl.pop ? pos_inc(rp_ff) : rp_ff;
      count_in = count_ff + CW'(ctrl.push0) + CW'(ctrl.push1) - CW'(ctrl.pop);

      we0 = (ctrl.push0 && !wp_ff[0]) || (ctrl.push1 && !wp1[0]);
      we1 = (ctrl.push0 && wp_ff[0]) || (ctrl.push1 && wp1[0]);
      waddr0 = wp_ff[0] ? wp1[BAW:1] : wp_ff[BAW:1];
      waddr1 = wp_ff[0] ? wp_ff[BAW:1] : wp1[BAW:1];
      wd0 = wp_ff[0] ? ctrl.wdata1 : ctrl.wdata0;
      wd1 = wp_ff[0] ? ctrl.wdata0 : ctrl.wdata1;

      hit0 = ctrl.push0 && (wp_ff == rp_in);
      hit1 = ctrl.push1 && (wp1 == rp_in);
      byp_valid_in = hit0 || hit1;
      byp_data_in = hit0 ? ctrl.wdata0 : ctrl.wdata1;

      stat.empty = (count_ff == '0);
      stat.full = (count_ff == CW'(DEPTH));
      stat.room_lt2 = (count_ff >= CW'(DEPTH - 1));
      stat.next_full = (count_in == CW'(DEPTH));
      stat.next_empty = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         count_ff <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         count_ff <= count_in;
         byp_valid_ff <= byp_valid_in;
      end
      sel_ff <= rp_in[0];
      byp_data_ff <= byp_data_in;
   end

   uff_ram #(.WIDTH(8), .DEPTH(BD)) u_bank0 (
      .clock(clock), .we(we0), .waddr(waddr0), .wdata(wd0),
      .raddr(rp_in[BAW:1]), .rdata(q0)
   );

   uff_ram #(.WIDTH(8), .DEPTH(BD)) u_bank1 (
      .clock(clock), .we(we1), .waddr(waddr1), .wdata(wd1),
      .raddr(rp_in[BAW:1]), .rdata(q1)
   );

   assign head = byp_valid_ff ? byp_data_ff : (sel_ff ? q1 : q0);

endmodule

// ===== design/uff_ctrl.sv =====
module uff_ctrl
   import uff_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  logic [1:0]     req_type,
   input  logic [7:0]     data,
   input  fifo_stat_type  tx_stat,
   input  fifo_stat_type  rx_stat,
   input  logic [7:0]     tx_head,
   input  logic [7:0]     rx_head,
   output fifo_ctrl_type  tx_ctrl,
   output fifo_ctrl_type  rx_ctrl,
   output rsp_fields_type res
);

   logic busy_ff, busy_in, stopped_ff, stopped_in;
   logic is_lf, direct, service, send_ok;

   always_comb begin
      tx_ctrl = '0;
      rx_ctrl = '0;
      res = '0;
      busy_in = busy_ff;
      stopped_in = stopped_ff;
      service = 1'b0;
      send_ok = 1'b0;
      is_lf = (data == CH_LF);
      direct = !busy_ff && !stopped_ff;
      tx_ctrl.wdata1 = CH_LF;
      rx_ctrl.wdata0 = data;
      rx_ctrl.wdata1 = data;
      if (go) begin
         unique case (req_type)
            REQ_WRITE: begin
               if (!tx_stat.full && (!is_lf || direct || !tx_stat.room_lt2)) begin
                  res.write_accepted = 1'b1;
                  if (direct) begin
                     res.line_tx_valid = 1'b1;
                     res.line_tx_byte = is_lf ? CH_CR : data;
                     busy_in = 1'b1;
                     tx_ctrl.push0 = is_lf;
                     tx_ctrl.wdata0 = CH_LF;
                  end else begin
                     tx_ctrl.push0 = 1'b1;
                     tx_ctrl.wdata0 = is_lf ? CH_CR : data;
                     tx_ctrl.push1 = is_lf;
                  end
               end
            end
            REQ_READ: begin
               if (!rx_stat.empty) begin
                  res.host_rd_valid = 1'b1;
                  res.host_rd_byte = rx_head;
                  rx_ctrl.pop = 1'b1;
               end
            end
            REQ_RECV: begin
               if (data == CH_XOFF) begin
                  stopped_in = 1'b1;
               end else if (data == CH_XON) begin
                  stopped_in = 1'b0;
                  service = stopped_ff;
                  send_ok = 1'b1;
               end else if (!rx_stat.full) begin
                  rx_ctrl.push0 = 1'b1;
               end
            end
            REQ_DONE: begin
               service = 1'b1;
               send_ok = !stopped_ff;
            end
         endcase
      end
      if (service) begin
         if (!tx_stat.empty) begin
            if (send_ok) begin
               res.line_tx_valid = 1'b1;
               res.line_tx_byte = tx_head;
               tx_ctrl.pop = 1'b1;
               busy_in = 1'b1;
            end
         end else begin
            busy_in = 1'b0;
         end
      end
      res.tx_full = tx_stat.next_full;
      res.rx_empty = rx_stat.next_empty;
      res.tx_stopped = stopped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         stopped_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== design/uart_fifo_xon_xoff.sv =====
// UART-side transmit and receive FIFO pair with XON/XOFF flow control.
// The request channel (req_) carries one event per beat: a host write, a
// host read, a byte received from the line, or a transmit-done event.
// The response channel (rsp_) returns exactly one beat per request, in
// order, with the byte handed to the line, the byte read by the host, the
// write status and the FIFO and flow flags after the event.
// A request beat lands in an input register; once the response register is
// empty or not stalled, its event is applied to the FIFOs and flow state and
// the result is loaded into the response register, which drives its response beat.
// Throughput is one beat per cycle while the receiver does not stall; the head
// byte of each FIFO is read ahead at the next read position from two-bank RAMs,
// which lets a line feed push both CR and LF in the same cycle.
// When the receiver stalls, the response register holds its beat and the
// input register still takes one more request; after that req_stall rises.
// Synchronous reset empties both FIFOs, clears the transmitter busy and
// XOFF state, and drops any beat in flight. No clearing pass is needed.
module uart_fifo_xon_xoff
   import uff_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEFAULT,
   parameter int RX_DEPTH = RX_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_line_tx_valid,
   output logic [7:0] rsp_line_tx_byte,
   output logic       rsp_host_rd_valid,
   output logic [7:0] rsp_host_rd_byte,
   output logic       rsp_write_accepted,
   output logic       rsp_tx_full,
   output logic       rsp_rx_empty,
   output logic       rsp_tx_stopped
);

   logic           in_valid_ff, in_valid_in, rsp_valid_ff, rsp_valid_in, go;
   logic [1:0]     in_type_ff;
   logic [7:0]     in_data_ff, tx_head, rx_head;
   fifo_ctrl_type  tx_ctrl, rx_ctrl;
   fifo_stat_type  tx_stat, rx_stat;
   rsp_fields_type res, res_ff;

   assign go = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !go;

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else begin
         in_valid_in = in_valid_ff && !go;
      end
      rsp_valid_in = go || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_type_ff <= req_type;
         in_data_ff <= req_data;
      end
      if (go) begin
         res_ff <= res;
      end
   end

   uff_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(go),
      .req_type(in_type_ff), .data(in_data_ff),
      .tx_stat(tx_stat), .rx_stat(rx_stat),
      .tx_head(tx_head), .rx_head(rx_head),
      .tx_ctrl(tx_ctrl), .rx_ctrl(rx_ctrl), .res(res)
   );

   uff_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
      .clock(clock), .reset(reset), .ctrl(tx_ctrl), .stat(tx_stat), .head(tx_head)
   );

   uff_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
      .clock(clock), .reset(reset), .ctrl(rx_ctrl), .stat(rx_stat), .head(rx_head)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_line_tx_valid = res_ff.line_tx_valid;
   assign rsp_line_tx_byte = res_ff.line_tx_byte;
   assign rsp_host_rd_valid = res_ff.host_rd_valid;
   assign rsp_host_rd_byte = res_ff.host_rd_byte;
   assign rsp_write_accepted = res_ff.write_accepted;
   assign rsp_tx_full = res_ff.tx_full;
   assign rsp_rx_empty = res_ff.rx_empty;
   assign rsp_tx_stopped = res_ff.tx_stopped;

endmodule

// ===== design/uff_checker.sv =====
module uff_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_line_tx_valid,
   input logic [7:0] rsp_line_tx_byte,
   input logic       rsp_host_rd_valid,
   input logic [7:0] rsp_host_rd_byte,
   input logic       rsp_write_accepted,
   input logic       rsp_tx_full,
   input logic       rsp_rx_empty,
   input logic       rsp_tx_stopped
);

   // An accepted request always finds a response beat valid once it has passed the input
   // and response registers, either freshly produced or an earlier one still held by a stall.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ##1 rsp_valid)
      else $error("accepted request produced no response");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_line_tx_byte)
         && $stable(rsp_host_rd_byte) && $stable(rsp_tx_stopped)
         && $stable(rsp_line_tx_valid) && $stable(rsp_host_rd_valid)
         && $stable(rsp_write_accepted) && $stable(rsp_tx_full)
         && $stable(rsp_rx_empty)))
      else $error("stalled response beat changed");

   // A beat that hands nothing to the line or the host carries zero bytes.
   a_zero_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_line_tx_valid || rsp_line_tx_byte == 8'h00)
         && (rsp_host_rd_valid || rsp_host_rd_byte == 8'h00)))
      else $error("byte field set without its valid flag");

endmodule

bind uart_fifo_xon_xoff uff_checker u_uff_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import uff_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      logic [1:0]     kind;
      logic [7:0]     data;
      bit             has_want;
      rsp_fields_type want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = REQ_READ;
   logic [7:0] req_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_line_tx_valid;
   logic [7:0] rsp_line_tx_byte;
   logic       rsp_host_rd_valid;
   logic [7:0] rsp_host_rd_byte;
   logic       rsp_write_accepted;
   logic       rsp_tx_full;
   logic       rsp_rx_empty;
   logic       rsp_tx_stopped;

   uart_fifo_xon_xoff u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_tx_valid  (rsp_line_tx_valid),
      .rsp_line_tx_byte   (rsp_line_tx_byte),
      .rsp_host_rd_valid  (rsp_host_rd_valid),
      .rsp_host_rd_byte   (rsp_host_rd_byte),
      .rsp_write_accepted (rsp_write_accepted),
      .rsp_tx_full        (rsp_tx_full),
      .rsp_rx_empty       (rsp_rx_empty),
      .rsp_tx_stopped     (rsp_tx_stopped)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the FIFO pair and the flow state.
   logic [7:0] tx_mem [8];
   logic [7:0] rx_mem [8];
   logic [3:0] tx_rp = '0;
   logic [3:0] tx_wp = '0;
   logic [3:0] rx_rp = '0;
   logic [3:0] rx_wp = '0;
   bit         tx_busy = 1'b0;
   bit         xoff_held = 1'b0;

   rsp_fields_type pending_rsp [$];
   stim_row_type   dir_rows [$];
   bit             row_has_want = 1'b0;
   rsp_fields_type row_want = '0;
   int             mismatches = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             stall_mode = 0;
   int             stall_left = 0;

   function automatic void tx_kick(inout rsp_fields_type r);
      if (tx_wp != tx_rp) begin
         if (!xoff_held) begin
            r.line_tx_valid = 1'b1;
            r.line_tx_byte  = tx_mem[tx_rp[2:0]];
            tx_rp           = tx_rp + 4'd1;
            tx_busy         = 1'b1;
         end
      end else begin
         tx_busy = 1'b0;
      end
   endfunction

   function automatic rsp_fields_type uart_next_rsp(logic [1:0] kind, logic [7:0] d);
      rsp_fields_type r;
      logic [3:0]     used;
      bit             direct;
      int             need;
      r = '0;
      case (kind)
         REQ_WRITE: begin
            used   = tx_wp - tx_rp;
            direct = !tx_busy && !xoff_held;
            if (d == CH_LF) need = direct ? 1 : 2;
            else need = direct ? 0 : 1;
            if (used < 4'd8 && 8 - int'(used) >= need) begin
               r.write_accepted = 1'b1;
               if (direct) begin
                  r.line_tx_valid = 1'b1;
                  r.line_tx_byte  = (d == CH_LF) ? CH_CR : d;
                  tx_busy         = 1'b1;
               end else begin
                  tx_mem[tx_wp[2:0]] = (d == CH_LF) ? CH_CR : d;
                  tx_wp              = tx_wp + 4'd1;
               end
               if (d == CH_LF) begin
                  tx_mem[tx_wp[2:0]] = d;
                  tx_wp              = tx_wp + 4'd1;
               end
            end
         end
         REQ_READ: begin
            if (rx_wp != rx_rp) begin
               r.host_rd_valid = 1'b1;
               r.host_rd_byte  = rx_mem[rx_rp[2:0]];
               rx_rp           = rx_rp + 4'd1;
            end
         end
         REQ_RECV: begin
            if (d == CH_XOFF) begin
               xoff_held = 1'b1;
            end else if (d == CH_XON) begin
               if (xoff_held) begin
                  xoff_held = 1'b0;
                  tx_kick(r);
               end
            end else if ((rx_wp - rx_rp) != 4'd8) begin
               rx_mem[rx_wp[2:0]] = d;
               rx_wp              = rx_wp + 4'd1;
            end
         end
         REQ_DONE: begin
            tx_kick(r);
         end
      endcase
      r.tx_full    = ((tx_wp - tx_rp) == 4'd8);
      r.rx_empty   = (rx_wp == rx_rp);
      r.tx_stopped = xoff_held;
      return r;
   endfunction

   function automatic rsp_fields_type lit(bit tv, logic [7:0] tb, bit rv, logic [7:0] rb,
                                          bit acc, bit full, bit empty, bit stop);
      rsp_fields_type r;
      r.line_tx_valid  = tv;
      r.line_tx_byte   = tb;
      r.host_rd_valid  = rv;
      r.host_rd_byte   = rb;
      r.write_accepted = acc;
      r.tx_full        = full;
      r.rx_empty       = empty;
      r.tx_stopped     = stop;
      return r;
   endfunction

   function automatic string fmt_rsp(rsp_fields_type r);
      return $sformatf("tx %b/%h rd %b/%h acc %b full %b empty %b stop %b",
                       r.line_tx_valid, r.line_tx_byte, r.host_rd_valid, r.host_rd_byte,
                       r.write_accepted, r.tx_full, r.rx_empty, r.tx_stopped);
   endfunction

   task automatic add_row(logic [1:0] kind, logic [7:0] d, bit has_want, rsp_fields_type want);
      stim_row_type row;
      row.kind     = kind;
      row.data     = d;
      row.has_want = has_want;
      row.want     = want;
      dir_rows.push_back(row);
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
   endtask

   task automatic send_beat(logic [1:0] kind, logic [7:0] d, bit has_want,
                            rsp_fields_type want);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_data     <= d;
      row_has_want = has_want;
      row_want     = want;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 1);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      rsp_fields_type model;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = lit(rsp_line_tx_valid, rsp_line_tx_byte, rsp_host_rd_valid,
                      rsp_host_rd_byte, rsp_write_accepted, rsp_tx_full, rsp_rx_empty,
                      rsp_tx_stopped);
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("ERROR: unexpected beat: %s", fmt_rsp(got));
            end else begin
               want = pending_rsp.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: expected %s", fmt_rsp(want));
                     $display("       actual   %s", fmt_rsp(got));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            model = uart_next_rsp(req_type, req_data);
            pending_rsp.push_back(row_has_want ? row_want : model);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int         mode;
      int         r;
      int         p;
      logic [1:0] kind;
      logic [7:0] d;

      add_row(REQ_READ,  8'h00,   1, lit(0, 8'h00, 0, 8'h00, 0, 0, 1, 0));
      add_row(REQ_DONE,  8'h00,   1, lit(0, 8'h00, 0, 8'h00, 0, 0, 1, 0));
      add_row(REQ_WRITE, 8'h00,   1, lit(1, 8'h00, 0, 8'h00, 1, 0, 1, 0));
      add_row(REQ_WRITE, 8'hFF,   1, lit(0, 8'h00, 0, 8'h00, 1, 0, 1, 0));
      add_row(REQ_RECV,  CH_XOFF, 1, lit(0, 8'h00, 0, 8'h00, 0, 0, 1, 1));
      add_row(REQ_DONE,  8'hFF,   1, lit(0, 8'h00, 0, 8'h00, 0, 0, 1, 1));
      add_row(REQ_RECV,  CH_XON,  1, lit(1, 8'hFF, 0, 8'h00, 0, 0, 1, 0));
      add_row(REQ_WRITE, CH_LF,   0, '0);
      add_row(REQ_WRITE, 8'h55,   0, '0);
      add_row(REQ_WRITE, 8'hAA,   0, '0);
      add_row(REQ_WRITE, 8'h01,   0, '0);
      add_row(REQ_WRITE, 8'h80,   0, '0);
      add_row(REQ_WRITE, 8'h7F,   0, '0);
      add_row(REQ_WRITE, CH_LF,   1, lit(0, 8'h00, 0, 8'h00, 0, 0, 1, 0));
      add_row(REQ_WRITE, 8'hFE,   1, lit(0, 8'h00, 0, 8'h00, 1, 1, 1, 0));
      add_row(REQ_WRITE, 8'h01,   1, lit(0, 8'h00, 0, 8'h00, 0, 1, 1, 0));
      add_row(REQ_RECV,  8'h00,   0, '0);
      add_row(REQ_RECV,  8'hFF,   0, '0);
      add_row(REQ_RECV,  8'hA5,   0, '0);
      add_row(REQ_RECV,  8'h5A,   0, '0);
      add_row(REQ_RECV,  CH_LF,   0, '0);
      add_row(REQ_RECV,  CH_CR,   0, '0);
      add_row(REQ_RECV,  8'h12,   0, '0);
      add_row(REQ_RECV,  8'h14,   0, '0);
      add_row(REQ_RECV,  8'h33,   1, lit(0, 8'h00, 0, 8'h00, 0, 1, 0, 0));
      add_row(REQ_READ,  8'h00,   0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         pace();
         send_beat(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].has_want,
                   dir_rows[i].want);
      end

      // Most stretches lean toward filling one of the two FIFOs or draining both; the rest pick kinds uniformly.
      mode = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) mode = $urandom_range(0, 3);
         r = $urandom_range(0, 99);
         case (mode)
            0: kind = (r < 50) ? REQ_WRITE : (r < 80) ? REQ_DONE : (r < 95) ? REQ_RECV : REQ_READ;
            1: kind = (r < 50) ? REQ_RECV : (r < 70) ? REQ_READ : (r < 85) ? REQ_WRITE : REQ_DONE;
            2: kind = (r < 40) ? REQ_READ : (r < 80) ? REQ_DONE : (r < 90) ? REQ_WRITE : REQ_RECV;
            default: kind = 2'($urandom_range(0, 3));
         endcase
         d = 8'($urandom);
         p = $urandom_range(0, 99);
         if (kind == REQ_RECV) begin
            if (p < 12) d = CH_XOFF;
            else if (p < 26) d = CH_XON;
         end else if (kind == REQ_WRITE && p < 15) begin
            d = CH_LF;
         end
         pace();
         send_beat(kind, d, 0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== uart_fifo_xon_xoff.f =====
design/uff_pkg.sv
design/uff_ram.sv
design/uff_fifo.sv
design/uff_ctrl.sv
design/uart_fifo_xon_xoff.sv
design/uff_checker.sv
tb/tb_top.sv
